FILE: design/ptw_pkg.sv
package ptw_pkg;

  localparam int PhysAddrBits = 52;

  typedef enum logic [1:0] {
    KIND_REQUEST = 2'd0,
    KIND_READ    = 2'd1,
    KIND_SWAP    = 2'd2,
    KIND_NONE    = 2'd3
  } in_kind_t;

  typedef enum logic [1:0] {
    RES_READ  = 2'd0,
    RES_SWAP  = 2'd1,
    RES_DONE  = 2'd2,
    RES_FAULT = 2'd3
  } res_kind_t;

  typedef enum logic [2:0] {
    CFG_MODE  = 3'd0,
    CFG_ROOT  = 3'd1,
    CFG_FLAGS = 3'd2,
    CFG_PDPT0 = 3'd3,
    CFG_PDPT1 = 3'd4,
    CFG_PDPT2 = 3'd5,
    CFG_PDPT3 = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] lin_address;
    logic        write_access;
    logic        is_fetch;
    logic        implicit_supervisor;
    logic [63:0] read_data;
    logic        swap_ok;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [63:0] address;
    logic        wide_entry;
    logic [63:0] old_entry;
    logic [63:0] new_entry;
    logic [51:0] frame;
    logic [4:0]  page_order;
    logic        writable;
    logic        user_ok;
    logic        no_execute;
    logic        dirty;
    logic [4:0]  error_code;
  } out_item_t;

endpackage

FILE: design/ptw_if.sv
interface ptw_in_if;
  logic                valid;
  logic                ready;
  ptw_pkg::in_item_t   data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ptw_out_if;
  logic                valid;
  logic                ready;
  ptw_pkg::out_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/ptw_front.sv
// Input queue: two entries, lets the input side run while the walk core stalls.
module ptw_front (
  input  logic               clk,
  input  logic               rst,
  ptw_in_if.sink             in_ch,
  output logic               q_valid,
  output ptw_pkg::in_item_t  q_item,
  input  logic               q_pop
);
  ptw_pkg::in_item_t slot [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       push;

  assign in_ch.ready = (count != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (count != 2'd0);
  assign q_item = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(q_pop && !q_valid))
    else $error("pop from empty input queue");
  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("input queue count overflow");
  assert property (@(posedge clk) disable iff (rst) !(push && count == 2'd2))
    else $error("push into full input queue");
endmodule

FILE: design/ptw_core.sv
// Walk engine: consumes one queued item per cycle while its output can take a result; registers at most one result.
module ptw_core #(
  parameter int PHYS_ADDR_BITS = ptw_pkg::PhysAddrBits
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  ptw_pkg::in_item_t  q_item,
  output logic               q_pop,
  input  logic [1:0]         walk_mode,
  input  logic [51:0]        table_root,
  input  logic [5:0]         mode_flags,
  input  logic [63:0]        pdpte [4],
  ptw_out_if.source          out_ch
);
  localparam logic [51:0] PhysMask = 52'((65'd1 << PHYS_ADDR_BITS) - 65'd1);
  localparam logic [51:0] Mask52 = {40'hFF_FFFF_FFFF, 12'h000};

  logic        busy, awaiting_swap;
  logic [1:0]  walk_level;
  logic [51:0] entry_address;
  logic [63:0] held_entry, saved_linear;
  logic [2:0]  saved_access, acc_perm;

  logic        busy_next, swap_next;
  logic [1:0]  level_next;
  logic [51:0] eaddr_next;
  logic [63:0] held_next, lin_next;
  logic [2:0]  acc_next, perm_next;

  logic               out_valid;
  ptw_pkg::out_item_t out_reg;
  logic               emit;
  ptw_pkg::out_item_t res;

  assign out_ch.valid = out_valid;
  assign out_ch.data = out_reg;
  assign q_pop = q_valid && (!out_valid || out_ch.ready);

  // Working copies as the step progresses.
  logic        narrow;
  logic [63:0] lin;
  logic [2:0]  acc, perm;
  logic [1:0]  lvl;
  logic [51:0] ebase;
  logic        f_sup, f_write, f_fetch;

  function automatic logic [51:0] entry_addr(input logic nar, input logic [1:0] lv,
                                             input logic [51:0] base, input logic [63:0] la);
    logic [51:0] idx;
    logic [5:0]  sh;
    begin
      if (nar) begin
        idx = (lv != 2'd0) ? {42'd0, la[31:22]} : {42'd0, la[21:12]};
        entry_addr = base + {idx[49:0], 2'b00};
      end else begin
        sh = 6'd12 + 6'd9 * {4'd0, lv};
        idx = {43'd0, 9'(la >> sh)};
        entry_addr = base + {idx[48:0], 3'b000};
      end
    end
  endfunction

  always_comb begin
    logic [63:0] e, upd, p, lowmask;
    logic        leaf, allowed, nxe;
    logic [4:0]  ord, ec;
    logic        do_begin, do_advance;
    busy_next = busy;
    swap_next = awaiting_swap;
    level_next = walk_level;
    eaddr_next = entry_address;
    held_next = held_entry;
    lin_next = saved_linear;
    acc_next = saved_access;
    perm_next = acc_perm;
    emit = 1'b0;
    res = '0;
    narrow = (walk_mode == 2'd1);
    lin = saved_linear;
    acc = saved_access;
    perm = acc_perm;
    lvl = walk_level;
    ebase = entry_address;
    e = held_entry;
    upd = '0;
    p = '0;
    lowmask = '0;
    leaf = 1'b0;
    allowed = 1'b0;
    ord = '0;
    ec = '0;
    do_begin = 1'b0;
    do_advance = 1'b0;
    nxe = mode_flags[3];

    if (q_pop) begin
      unique case (ptw_pkg::in_kind_t'(q_item.kind))
        ptw_pkg::KIND_REQUEST: begin
          if (!busy) begin
            lin = q_item.lin_address;
            acc = {q_item.implicit_supervisor, q_item.is_fetch, q_item.write_access};
            lin_next = lin;
            acc_next = acc;
            busy_next = 1'b1;
            do_begin = 1'b1;
          end
        end
        ptw_pkg::KIND_READ: begin
          if (busy && !awaiting_swap) begin
            e = narrow ? {32'd0, q_item.read_data[31:0]} : q_item.read_data;
            held_next = e;
          end
        end
        ptw_pkg::KIND_SWAP: begin
          if (busy && awaiting_swap) begin
            swap_next = 1'b0;
            if (q_item.swap_ok) do_advance = 1'b1;
            else do_begin = 1'b1;
          end
        end
        default: ;
      endcase
    end

    f_write = acc[0];
    f_fetch = acc[1];
    f_sup = acc[2] || mode_flags[5];
    ec = {f_fetch && (mode_flags[2] || (mode_flags[1] && nxe)), 1'b0, !f_sup, f_write, 1'b0};

    if (q_pop && q_item.kind == ptw_pkg::KIND_READ && busy && !awaiting_swap) begin
      if (!e[0]) begin
        emit = 1'b1;
        res.result_kind = ptw_pkg::RES_FAULT;
        res.address = lin;
        res.error_code = ec;
        busy_next = 1'b0;
        swap_next = 1'b0;
      end else begin
        if (lvl == 2'd0) leaf = 1'b1;
        else if (narrow) leaf = mode_flags[0] && e[7];
        else if (lvl == 2'd3) leaf = 1'b0;
        else leaf = e[7];
        if (!e[1]) perm[0] = 1'b0;
        if (!e[2]) perm[1] = 1'b0;
        if (!narrow && e[63]) perm[2] = 1'b1;
        perm_next = perm;
        if (f_fetch && perm[2] && nxe) allowed = 1'b0;
        else if (!f_sup) allowed = perm[1] && !(f_write && !perm[0]);
        else allowed = !(f_write && !perm[0] && mode_flags[4])
                       && !(f_fetch && perm[1] && mode_flags[2]);
        upd = e | 64'h20 | ((leaf && f_write) ? 64'h40 : 64'h0);
        if (leaf && !allowed) begin
          emit = 1'b1;
          res.result_kind = ptw_pkg::RES_FAULT;
          res.address = lin;
          res.error_code = ec | 5'd1;
          busy_next = 1'b0;
          swap_next = 1'b0;
        end else if (upd != e) begin
          emit = 1'b1;
          res.result_kind = ptw_pkg::RES_SWAP;
          res.address = {12'd0, entry_addr(narrow, lvl, ebase, lin)};
          res.wide_entry = !narrow;
          res.old_entry = e;
          res.new_entry = upd;
          swap_next = 1'b1;
        end else begin
          do_advance = 1'b1;
        end
      end
    end

    if (do_advance) begin
      if (lvl == 2'd0) leaf = 1'b1;
      else if (narrow) leaf = mode_flags[0] && e[7];
      else if (lvl == 2'd3) leaf = 1'b0;
      else leaf = e[7];
      if (leaf) begin
        if (narrow) ord = (lvl != 2'd0) ? 5'd22 : 5'd12;
        else ord = 5'(6'd12 + 6'd9 * {4'd0, lvl});
        lowmask = (64'd1 << ord) - 64'd1;
        emit = 1'b1;
        res.result_kind = ptw_pkg::RES_DONE;
        res.address = lin & ~lowmask;
        res.frame = narrow ? (e[51:0] & 52'hFFFFFFFF & ~lowmask[51:0])
                           : (e[51:0] & PhysMask & ~lowmask[51:0]);
        res.page_order = ord;
        res.writable = perm[0];
        res.user_ok = perm[1];
        res.no_execute = perm[2];
        res.dirty = e[6] | f_write;
        busy_next = 1'b0;
        swap_next = 1'b0;
      end else begin
        ebase = narrow ? {20'd0, e[31:12], 12'd0} : (e[51:0] & Mask52 & PhysMask);
        lvl = lvl - 2'd1;
        eaddr_next = ebase;
        level_next = lvl;
        emit = 1'b1;
        res.result_kind = ptw_pkg::RES_READ;
        res.address = {12'd0, entry_addr(narrow, lvl, ebase, lin)};
        res.wide_entry = !narrow;
      end
    end

    if (do_begin) begin
      perm_next = 3'b011;
      swap_next = 1'b0;
      unique case (walk_mode)
        2'd0: begin
          emit = 1'b1;
          res.result_kind = ptw_pkg::RES_DONE;
          res.address = {lin[63:12], 12'd0};
          res.frame = {lin[51:12], 12'd0};
          res.page_order = 5'd12;
          res.writable = 1'b1;
          res.user_ok = 1'b1;
          busy_next = 1'b0;
        end
        2'd2: begin
          p = pdpte[lin[31:30]];
          if (!p[0]) begin
            emit = 1'b1;
            res.result_kind = ptw_pkg::RES_FAULT;
            res.address = lin;
            res.error_code = ec;
            busy_next = 1'b0;
          end else begin
            ebase = p[51:0] & Mask52 & PhysMask;
            lvl = 2'd1;
          end
        end
        2'd1: begin
          ebase = {20'd0, table_root[31:12], 12'd0};
          lvl = 2'd1;
        end
        default: begin
          ebase = table_root & Mask52 & PhysMask;
          lvl = 2'd3;
        end
      endcase
      if (!emit) begin
        eaddr_next = ebase;
        level_next = lvl;
        emit = 1'b1;
        res.result_kind = ptw_pkg::RES_READ;
        res.address = {12'd0, entry_addr(narrow, lvl, ebase, lin)};
        res.wide_entry = !narrow;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      awaiting_swap <= 1'b0;
      walk_level <= 2'd0;
      entry_address <= '0;
      saved_access <= 3'd0;
      acc_perm <= 3'b011;
      out_valid <= 1'b0;
    end else begin
      busy <= busy_next;
      awaiting_swap <= swap_next;
      walk_level <= level_next;
      entry_address <= eaddr_next;
      saved_access <= acc_next;
      acc_perm <= perm_next;
      if (q_pop) out_valid <= emit;
      else if (out_ch.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    held_entry <= held_next;
    saved_linear <= lin_next;
    if (q_pop && emit) out_reg <= res;
  end

  assert property (@(posedge clk) disable iff (rst) !(awaiting_swap && !busy))
    else $error("swap pending while idle");
  assert property (@(posedge clk) disable iff (rst) !(q_pop && out_valid && !out_ch.ready))
    else $error("result overwritten");
  assert property (@(posedge clk) disable iff (rst)
                   !(out_valid && out_ch.data.result_kind == ptw_pkg::RES_FAULT
                     && out_ch.data.error_code[3]))
    else $error("RSVD set in fault");
endmodule

FILE: design/x86_page_table_walker.sv
// The input transfer writes the item into the input queue; the result register loads
// at the edge that pops the item from the queue, and that pop waits while the result
// register holds a result that has not been taken.
// Throughput: one item per cycle while results are taken; the two-entry input queue
// and the result register keep both sides moving between stalls.
// Reset (synchronous, rst high) empties the queue, clears the walk state and the
// configuration registers; no clearing pass is needed.
module x86_page_table_walker #(
  parameter int PHYS_ADDR_BITS = ptw_pkg::PhysAddrBits
) (
  input  logic        clk,
  input  logic        rst,
  ptw_in_if.sink      in_ch,
  ptw_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  // Configuration registers. Write only while idle; the block does not check this.
  logic [1:0]  walk_mode;
  logic [51:0] table_root;
  logic [5:0]  mode_flags;
  logic [63:0] pdpte [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_mode <= '0;
      table_root <= '0;
      mode_flags <= '0;
      pdpte[0] <= '0;
      pdpte[1] <= '0;
      pdpte[2] <= '0;
      pdpte[3] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ptw_pkg::CFG_MODE:  walk_mode <= cfg_data[1:0];
        ptw_pkg::CFG_ROOT:  table_root <= cfg_data[51:0];
        ptw_pkg::CFG_FLAGS: mode_flags <= cfg_data[5:0];
        ptw_pkg::CFG_PDPT0: pdpte[0] <= cfg_data;
        ptw_pkg::CFG_PDPT1: pdpte[1] <= cfg_data;
        ptw_pkg::CFG_PDPT2: pdpte[2] <= cfg_data;
        ptw_pkg::CFG_PDPT3: pdpte[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // The front queue decouples the transfer side from the walk engine.
  logic              q_valid;
  logic              q_pop;
  ptw_pkg::in_item_t q_item;

  ptw_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  // The walk engine classifies each item against its state and issues the
  // next read, a compare-exchange, a translation or a fault.
  ptw_core #(.PHYS_ADDR_BITS(PHYS_ADDR_BITS)) u_core (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .walk_mode(walk_mode), .table_root(table_root), .mode_flags(mode_flags),
    .pdpte(pdpte), .out_ch(out_ch)
  );
endmodule

FILE: dv/x86_page_table_walker_tb.sv
`timescale 1ns / 1ps

module x86_page_table_walker_tb;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 10;
  localparam int RandomPerPhase = 155;
  localparam int PhaseCount = 8;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [63:0] cfg_data;

  ptw_in_if in_ch ();
  ptw_out_if out_ch ();

  x86_page_table_walker dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // The clock starts high so that the first falling edge comes half a period in.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Shadow copy of the configuration registers as the walker sees them.
  logic [1:0]  sh_mode;
  logic [51:0] sh_root;
  logic [5:0]  sh_flags;
  logic [63:0] sh_pdpte [4];

  // Shadow walk state.
  logic        wk_busy;
  logic        wk_swap;
  logic [1:0]  wk_level;
  logic [51:0] wk_base;
  logic [63:0] wk_entry;
  logic [63:0] wk_linear;
  logic [2:0]  wk_access;
  logic [2:0]  wk_perm;

  ptw_pkg::out_item_t pending_results [$];
  int errors = 0;
  int cycles = 0;
  int src_idle = 0;
  int snk_idle = 0;
  int sent_count = 0;
  int hold_left = 0;
  bit hold_used = 0;

  function automatic bit narrow_mode();
    return sh_mode == 2'd1;
  endfunction

  function automatic bit sup_access();
    return wk_access[2] | sh_flags[5];
  endfunction

  function automatic void shadow_config(logic [2:0] idx, logic [63:0] val);
    case (idx)
      ptw_pkg::CFG_MODE:  sh_mode = val[1:0];
      ptw_pkg::CFG_ROOT:  sh_root = val[51:0];
      ptw_pkg::CFG_FLAGS: sh_flags = val[5:0];
      ptw_pkg::CFG_PDPT0: sh_pdpte[0] = val;
      ptw_pkg::CFG_PDPT1: sh_pdpte[1] = val;
      ptw_pkg::CFG_PDPT2: sh_pdpte[2] = val;
      ptw_pkg::CFG_PDPT3: sh_pdpte[3] = val;
      default: ;
    endcase
  endfunction

  // A fault carries the access type; the instruction-fetch bit is only
  // reported when SMEP or PAE with NXE is on.
  function automatic void walk_fault(bit present, output ptw_pkg::out_item_t r);
    r = '0;
    r.result_kind = ptw_pkg::RES_FAULT;
    r.address = wk_linear;
    r.error_code[0] = present;
    r.error_code[1] = wk_access[0];
    r.error_code[2] = !sup_access();
    r.error_code[4] = wk_access[1] & (sh_flags[2] | (sh_flags[1] & sh_flags[3]));
    wk_busy = 0;
    wk_swap = 0;
  endfunction

  function automatic logic [51:0] entry_addr();
    logic [51:0] idx;
    if (narrow_mode()) begin
      idx = (wk_level != 0) ? 52'(wk_linear[31:22]) : 52'(wk_linear[21:12]);
      return wk_base + (idx << 2);
    end
    idx = 52'((wk_linear >> (12 + 9 * wk_level)) & 64'd511);
    return wk_base + (idx << 3);
  endfunction

  function automatic void walk_read(output ptw_pkg::out_item_t r);
    r = '0;
    r.result_kind = ptw_pkg::RES_READ;
    r.address = 64'(entry_addr());
    r.wide_entry = !narrow_mode();
    wk_busy = 1;
  endfunction

  function automatic bit leaf_entry(logic [63:0] e);
    if (wk_level == 0) return 1;
    if (narrow_mode()) return sh_flags[0] & e[7];
    if (wk_level == 3) return 0;
    return e[7];
  endfunction

  function automatic void walk_begin(output ptw_pkg::out_item_t r);
    logic [63:0] p;
    wk_perm = 3'b011;
    wk_swap = 0;
    case (sh_mode)
      2'd0: begin
        r = '0;
        r.result_kind = ptw_pkg::RES_DONE;
        r.address = {wk_linear[63:12], 12'h0};
        r.frame = {wk_linear[51:12], 12'h0};
        r.page_order = 5'd12;
        r.writable = 1;
        r.user_ok = 1;
        wk_busy = 0;
      end
      2'd1: begin
        wk_base = {20'h0, sh_root[31:12], 12'h0};
        wk_level = 1;
        walk_read(r);
      end
      2'd2: begin
        p = sh_pdpte[wk_linear[31:30]];
        if (!p[0]) begin
          walk_fault(0, r);
        end else begin
          wk_base = {p[51:12], 12'h0};
          wk_level = 1;
          walk_read(r);
        end
      end
      default: begin
        wk_base = {sh_root[51:12], 12'h0};
        wk_level = 3;
        walk_read(r);
      end
    endcase
  endfunction

  function automatic bit access_ok();
    bit w, u, nx;
    w = wk_perm[0];
    u = wk_perm[1];
    nx = wk_perm[2] & sh_flags[3];
    if (wk_access[1] && nx) return 0;
    if (!sup_access()) return u && !(wk_access[0] && !w);
    if (wk_access[0] && !w && sh_flags[4]) return 0;
    if (wk_access[1] && u && sh_flags[2]) return 0;
    return 1;
  endfunction

  function automatic void walk_advance(output ptw_pkg::out_item_t r);
    logic [63:0] e, lowmask, fr;
    int ord;
    e = wk_entry;
    if (leaf_entry(e)) begin
      if (narrow_mode()) ord = (wk_level != 0) ? 22 : 12;
      else ord = 12 + 9 * wk_level;
      lowmask = (64'd1 << ord) - 64'd1;
      if (narrow_mode()) fr = e & 64'hFFFF_FFFF & ~lowmask;
      else fr = e & 64'h000F_FFFF_FFFF_FFFF & ~lowmask;
      r = '0;
      r.result_kind = ptw_pkg::RES_DONE;
      r.address = wk_linear & ~lowmask;
      r.frame = fr[51:0];
      r.page_order = 5'(ord);
      r.writable = wk_perm[0];
      r.user_ok = wk_perm[1];
      r.no_execute = wk_perm[2];
      r.dirty = e[6] | wk_access[0];
      wk_busy = 0;
      wk_swap = 0;
    end else begin
      if (narrow_mode()) wk_base = {20'h0, e[31:12], 12'h0};
      else wk_base = {e[51:12], 12'h0};
      wk_level = wk_level - 2'd1;
      walk_read(r);
    end
  endfunction

  function automatic void walk_entry(logic [63:0] data, output ptw_pkg::out_item_t r);
    logic [63:0] e, upd;
    bit leaf;
    e = narrow_mode() ? {32'h0, data[31:0]} : data;
    wk_entry = e;
    if (!e[0]) begin
      walk_fault(0, r);
      return;
    end
    leaf = leaf_entry(e);
    if (!e[1]) wk_perm[0] = 0;
    if (!e[2]) wk_perm[1] = 0;
    if (!narrow_mode() && e[63]) wk_perm[2] = 1;
    if (leaf && !access_ok()) begin
      walk_fault(1, r);
      return;
    end
    upd = e | 64'h20;
    if (leaf && wk_access[0]) upd = upd | 64'h40;
    if (upd != e) begin
      r = '0;
      r.result_kind = ptw_pkg::RES_SWAP;
      r.address = 64'(entry_addr());
      r.wide_entry = !narrow_mode();
      r.old_entry = e;
      r.new_entry = upd;
      wk_swap = 1;
      return;
    end
    walk_advance(r);
  endfunction

  // Returns 1 when the transfer causes a result, which is then left in r.
  function automatic bit walk_step(ptw_pkg::in_item_t it, output ptw_pkg::out_item_t r);
    r = '0;
    case (it.kind)
      ptw_pkg::KIND_REQUEST: begin
        if (wk_busy) return 0;
        wk_linear = it.lin_address;
        wk_access = {it.implicit_supervisor, it.is_fetch, it.write_access};
        wk_busy = 1;
        walk_begin(r);
        return 1;
      end
      ptw_pkg::KIND_READ: begin
        if (!wk_busy || wk_swap) return 0;
        walk_entry(it.read_data, r);
        return 1;
      end
      ptw_pkg::KIND_SWAP: begin
        if (!wk_busy || !wk_swap) return 0;
        wk_swap = 0;
        if (it.swap_ok) walk_advance(r);
        else walk_begin(r);
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  task automatic mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch in %s: got %h, expected %h", field, got, want);
    errors++;
  endtask

  // Output side: every transfer is held against the oldest expected result.
  always @(posedge clk) begin
    ptw_pkg::out_item_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_results.size() == 0) begin
        mismatch("unexpected result", 64'(got.result_kind), 64'h0);
      end else begin
        want = pending_results.pop_front();
        if (got.result_kind != want.result_kind)
          mismatch("result_kind", 64'(got.result_kind), 64'(want.result_kind));
        if (got.address != want.address) mismatch("address", got.address, want.address);
        if (got.wide_entry != want.wide_entry)
          mismatch("wide_entry", 64'(got.wide_entry), 64'(want.wide_entry));
        if (got.old_entry != want.old_entry)
          mismatch("old_entry", got.old_entry, want.old_entry);
        if (got.new_entry != want.new_entry)
          mismatch("new_entry", got.new_entry, want.new_entry);
        if (got.frame != want.frame) mismatch("frame", 64'(got.frame), 64'(want.frame));
        if (got.page_order != want.page_order)
          mismatch("page_order", 64'(got.page_order), 64'(want.page_order));
        if (got.writable != want.writable)
          mismatch("writable", 64'(got.writable), 64'(want.writable));
        if (got.user_ok != want.user_ok)
          mismatch("user_ok", 64'(got.user_ok), 64'(want.user_ok));
        if (got.no_execute != want.no_execute)
          mismatch("no_execute", 64'(got.no_execute), 64'(want.no_execute));
        if (got.dirty != want.dirty) mismatch("dirty", 64'(got.dirty), 64'(want.dirty));
        if (got.error_code != want.error_code)
          mismatch("error_code", 64'(got.error_code), 64'(want.error_code));
      end
    end
  end

  // Receiver. Once, after a few hundred transfers, it holds ready low for a long
  // stretch so that the input queue fills up and the sender is stalled.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!hold_used && sent_count >= 300) begin
      hold_used <= 1;
      hold_left <= 200;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("x86_page_table_walker_tb: errors");
      $finish;
    end
  end

  // Offers one item, waits for its transfer and records what it should cause.
  // A typed expectation, when given, replaces the predicted one.
  task automatic send_item(ptw_pkg::in_item_t it, bit typed = 0,
                           ptw_pkg::out_item_t typed_exp = '0);
    ptw_pkg::out_item_t r;
    bit has;
    while ($urandom_range(99) < src_idle) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    has = walk_step(it, r);
    if (typed) pending_results.push_back(typed_exp);
    else if (has) pending_results.push_back(r);
    sent_count++;
  endtask

  // Registers change only with nothing in flight: the sender pauses until all
  // expected results are back, then lets the pipeline drain.
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow_config(idx, val);
  endtask

  function automatic ptw_pkg::in_item_t make_item(logic [1:0] kind, logic [63:0] lin,
                                                  logic [2:0] acc, logic [63:0] data, bit ok);
    ptw_pkg::in_item_t it;
    it.kind = kind;
    it.lin_address = lin;
    it.write_access = acc[0];
    it.is_fetch = acc[1];
    it.implicit_supervisor = acc[2];
    it.read_data = data;
    it.swap_ok = ok;
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // A page-table entry that is usually present and permissive, so that most
  // walks reach a leaf; the rest exercise faults and permission loss.
  function automatic logic [63:0] rand_entry(bit force_present);
    logic [63:0] e;
    e = rand64();
    e[0] = force_present || ($urandom_range(99) < 90);
    e[1] = $urandom_range(99) < 80;
    e[2] = $urandom_range(99) < 80;
    e[5] = $urandom_range(1);
    e[6] = $urandom_range(99) < 30;
    e[7] = $urandom_range(99) < 30;
    e[63] = $urandom_range(99) < 30;
    return e;
  endfunction

  // Next well-formed item for the walk in progress: a request when idle, a
  // swap outcome when one is awaited, otherwise the entry that was asked for.
  function automatic ptw_pkg::in_item_t next_item(bit finishing);
    logic [63:0] lin;
    if (!wk_busy) begin
      lin = rand64();
      if ($urandom_range(3) == 0) lin = lin & 64'h0000_0000_FFFF_FFFF;
      return make_item(ptw_pkg::KIND_REQUEST, lin, 3'($urandom_range(7)), rand64(),
                       $urandom_range(1));
    end
    if (wk_swap)
      return make_item(ptw_pkg::KIND_SWAP, rand64(), 3'($urandom_range(7)), rand64(),
                       finishing || ($urandom_range(99) < 85));
    return make_item(ptw_pkg::KIND_READ, rand64(), 3'($urandom_range(7)),
                     rand_entry(finishing), $urandom_range(1));
  endfunction

  typedef struct {
    bit                 is_cfg;
    logic [2:0]         idx;
    logic [63:0]        val;
    ptw_pkg::in_item_t  item;
    bit                 typed;
    ptw_pkg::out_item_t want;
  } dir_row_t;

  initial begin
    dir_row_t rows [$];
    dir_row_t row;
    ptw_pkg::out_item_t done_top, done_zero, pae_fault;
    ptw_pkg::in_item_t it;
    int made;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    sh_mode = '0;
    sh_root = '0;
    sh_flags = '0;
    for (int i = 0; i < 4; i++) sh_pdpte[i] = '0;
    wk_busy = 0;
    wk_swap = 0;
    wk_level = '0;
    wk_base = '0;
    wk_entry = '0;
    wk_linear = '0;
    wk_access = '0;
    wk_perm = 3'b011;

    // Results that follow directly from the reset state, without paging.
    done_top = '0;
    done_top.result_kind = ptw_pkg::RES_DONE;
    done_top.address = 64'hFFFF_FFFF_FFFF_F000;
    done_top.frame = 52'hF_FFFF_FFFF_F000;
    done_top.page_order = 5'd12;
    done_top.writable = 1;
    done_top.user_ok = 1;
    done_zero = done_top;
    done_zero.address = '0;
    done_zero.frame = '0;
    // PAE with every PDPTE absent: a user write faults with P clear.
    pae_fault = '0;
    pae_fault.result_kind = ptw_pkg::RES_FAULT;
    pae_fault.error_code = 5'b00110;

    row = '{default: '0};
    row.typed = 1;
    row.want = done_top;
    row.item = make_item(ptw_pkg::KIND_REQUEST, '1, 3'b001, '1, 1);
    rows.push_back(row);
    row.want = done_zero;
    row.item = make_item(ptw_pkg::KIND_REQUEST, '0, 3'b110, '0, 0);
    rows.push_back(row);
    row = '{default: '0};
    // Stray items with no walk in progress are dropped.
    row.item = make_item(ptw_pkg::KIND_NONE, '1, 3'b111, '1, 1);
    rows.push_back(row);
    row.item = make_item(ptw_pkg::KIND_READ, '0, 3'b000, 64'h27, 0);
    rows.push_back(row);
    row.item = make_item(ptw_pkg::KIND_SWAP, '0, 3'b000, '0, 1);
    rows.push_back(row);
    row = '{default: '0};
    row.is_cfg = 1;
    row.idx = ptw_pkg::CFG_MODE;
    row.val = 64'd2;
    rows.push_back(row);
    row = '{default: '0};
    row.typed = 1;
    row.want = pae_fault;
    row.item = make_item(ptw_pkg::KIND_REQUEST, '0, 3'b011, '0, 0);
    rows.push_back(row);
    // 32-bit paging with 4 MiB pages, SMEP and NXE.
    row = '{default: '0};
    row.is_cfg = 1;
    row.idx = ptw_pkg::CFG_FLAGS;
    row.val = 64'b001101;
    rows.push_back(row);
    row.idx = ptw_pkg::CFG_ROOT;
    row.val = 64'h000F_FFFF_FFFF_FFFF;
    rows.push_back(row);
    row.idx = ptw_pkg::CFG_MODE;
    row.val = 64'd1;
    rows.push_back(row);
    row = '{default: '0};
    row.item = make_item(ptw_pkg::KIND_REQUEST, 64'hFFFF_FFFF_FFC0_0123, 3'b000, '0, 0);
    rows.push_back(row);
    row.item = make_item(ptw_pkg::KIND_READ, '0, 3'b000, 64'hFFFF_FFFF_FFC0_00A7, 0);
    rows.push_back(row);
    // A failed compare-exchange restarts the walk from the top.
    row.item = make_item(ptw_pkg::KIND_REQUEST, 64'h0040_1000, 3'b001, '0, 0);
    rows.push_back(row);
    row.item = make_item(ptw_pkg::KIND_READ, '0, 3'b000, 64'h0000_1007, 0);
    rows.push_back(row);
    row.item = make_item(ptw_pkg::KIND_SWAP, '0, 3'b000, '0, 0);
    rows.push_back(row);
    row.item = make_item(ptw_pkg::KIND_READ, '0, 3'b000, 64'h0000_1027, 0);
    rows.push_back(row);
    row.item = make_item(ptw_pkg::KIND_READ, '0, 3'b000, 64'h0, 0);
    rows.push_back(row);
    // Four-level walk with execute-disable, and a request while busy.
    row = '{default: '0};
    row.is_cfg = 1;
    row.idx = ptw_pkg::CFG_FLAGS;
    row.val = 64'd63;
    rows.push_back(row);
    row.idx = ptw_pkg::CFG_MODE;
    row.val = 64'd3;
    rows.push_back(row);
    row = '{default: '0};
    row.item = make_item(ptw_pkg::KIND_REQUEST, 64'hFFFF_8000_1234_5678, 3'b011, '0, 0);
    rows.push_back(row);
    row.item = make_item(ptw_pkg::KIND_REQUEST, '0, 3'b000, '0, 0);
    rows.push_back(row);
    row.item = make_item(ptw_pkg::KIND_READ, '0, 3'b000, 64'h8000_0000_0000_2027, 0);
    rows.push_back(row);
    row.item = make_item(ptw_pkg::KIND_READ, '0, 3'b000, 64'hFFFF_FFFF_FFFF_FFE7, 0);
    rows.push_back(row);
    row.item = make_item(ptw_pkg::KIND_READ, '0, 3'b000, 64'hFFFF_FFFF_FFFF_FF67, 0);
    rows.push_back(row);

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    src_idle = 6;
    snk_idle = 81;
    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_reg(rows[i].idx, rows[i].val);
      else send_item(rows[i].item, rows[i].typed, rows[i].want);
    end
    while (wk_busy) send_item(next_item(1));

    for (int ph = 0; ph < PhaseCount; ph++) begin
      // The idle pattern flips after the first three phases, then stops.
      if (ph == 3) begin
        src_idle = 81;
        snk_idle = 6;
      end else if (ph == 6) begin
        src_idle = 0;
        snk_idle = 0;
      end
      if (ph == 6) begin
        // All registers at their upper extreme.
        write_reg(ptw_pkg::CFG_MODE, 64'd3);
        write_reg(ptw_pkg::CFG_ROOT, 64'h000F_FFFF_FFFF_FFFF);
        write_reg(ptw_pkg::CFG_FLAGS, 64'd63);
        for (int k = 0; k < 4; k++) write_reg(3'(ptw_pkg::CFG_PDPT0 + k), '1);
      end else if (ph == 7) begin
        // Lower extreme of root and flags in 32-bit mode.
        write_reg(ptw_pkg::CFG_MODE, 64'd1);
        write_reg(ptw_pkg::CFG_ROOT, '0);
        write_reg(ptw_pkg::CFG_FLAGS, '0);
        for (int k = 0; k < 4; k++) write_reg(3'(ptw_pkg::CFG_PDPT0 + k), '0);
      end else begin
        write_reg(ptw_pkg::CFG_MODE, 64'(ph % 4));
        write_reg(ptw_pkg::CFG_ROOT, rand64() & 64'h000F_FFFF_FFFF_FFFF);
        write_reg(ptw_pkg::CFG_FLAGS, 64'($urandom_range(63)));
        for (int k = 0; k < 4; k++) begin
          it.read_data = rand64();
          it.read_data[0] = $urandom_range(99) < 85;
          write_reg(3'(ptw_pkg::CFG_PDPT0 + k), it.read_data);
        end
      end
      made = 0;
      while (made < RandomPerPhase) begin
        if ($urandom_range(99) < 10) begin
          // Noise: any kind, any content, often ignored by the walker.
          send_item(make_item(2'($urandom_range(3)), rand64(), 3'($urandom_range(7)),
                              rand64(), $urandom_range(1)));
        end else begin
          send_item(next_item(0));
          made++;
        end
      end
      // Bring the walk to its end before the next register writes.
      while (wk_busy) send_item(next_item(1));
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("x86_page_table_walker_tb: clean");
    end else begin
      $display("x86_page_table_walker_tb: errors");
    end
    $finish;
  end

endmodule
